/* rtl/lms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

	// Number of taps in the delay line and the coefficient set.
	localparam int TAPS = 10;
	localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

	// Q1.15 samples and Q0.15 step size.
	localparam int SAMPLE_W = 16;
	localparam int STEP_W = 15;
	localparam int PROD_W = 2 * SAMPLE_W;

	localparam logic [STEP_W-1:0] STEP_RESET = 15'd328;

	// Operand selection for the shared multiplier.
	typedef enum logic [1:0] {
		OP_FIR,
		OP_GAIN,
		OP_UPD
	} lms_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             shift;
		logic             acc_clr;
		logic             mul_en;
		lms_op_t          mul_op;
		logic [TAP_W-1:0] idx;
		logic             err_load;
		logic             out_load;
	} lms_cmd_t;

endpackage

`default_nettype wire

/* rtl/lms_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one sample and its desired value per word.
interface lms_in_if import lms_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic signed [SAMPLE_W-1:0] desired;

	modport source(output valid, output sample_in, output desired, input ready);
	modport sink(input valid, input sample_in, input desired, output ready);
endinterface

// Output channel: filter output and error per word.
interface lms_out_if import lms_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filter_out;
	logic signed [SAMPLE_W-1:0] error_out;

	modport source(output valid, output filter_out, output error_out, input ready);
	modport sink(input valid, input filter_out, input error_out, output ready);
endinterface

`default_nettype wire

/* rtl/lms_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lms_ctrl import lms_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	output lms_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIR,
		ST_ERR,
		ST_ERRL,
		ST_GAIN,
		ST_GWAIT,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [TAP_W-1:0] idx_q;
	logic             last_tap;
	logic             out_free;

	assign last_tap = (idx_q == TAP_W'(TAPS - 1));
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.mul_op   = OP_FIR;
		cmd.idx      = idx_q;
		case (state_q)
			ST_IDLE: begin
				cmd.shift   = in_valid;
				cmd.acc_clr = in_valid;
			end
			ST_FIR: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_FIR;
			end
			ST_ERRL: begin
				cmd.err_load = 1'b1;
			end
			ST_GAIN: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_GAIN;
			end
			ST_UPD: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = OP_UPD;
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// A new result takes the output register as the old one leaves it.
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_FIR;
						idx_q   <= '0;
					end
				end
				ST_FIR: begin
					if (last_tap) begin
						state_q <= ST_ERR;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				// The last filter product is accumulated here.
				ST_ERR: begin
					state_q <= ST_ERRL;
				end
				ST_ERRL: begin
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					state_q <= ST_GWAIT;
				end
				ST_GWAIT: begin
					state_q <= ST_UPD;
					idx_q   <= '0;
				end
				ST_UPD: begin
					if (last_tap) begin
						state_q <= ST_DONE;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/lms_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module lms_datapath import lms_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lms_cmd_t                   cmd,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic signed [SAMPLE_W-1:0] desired,
	input  wire logic                       cfg_we,
	input  wire logic [STEP_W-1:0]          cfg_wdata,
	output logic signed [SAMPLE_W-1:0]      filter_out,
	output logic signed [SAMPLE_W-1:0]      error_out
);

	logic signed [SAMPLE_W-1:0] delay_q [TAPS];
	logic signed [SAMPLE_W-1:0] weight_q [TAPS];
	logic        [STEP_W-1:0]   step_q;
	logic signed [SAMPLE_W-1:0] desired_q;
	logic signed [SAMPLE_W-1:0] acc_q;
	logic signed [SAMPLE_W-1:0] err_q;
	logic signed [SAMPLE_W-1:0] g_q;
	logic signed [SAMPLE_W-1:0] filter_q;
	logic signed [SAMPLE_W-1:0] error_q;

	logic signed [SAMPLE_W-1:0] mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [PROD_W-1:0]   prod_s1;
	lms_op_t                    op_s1;
	logic        [TAP_W-1:0]    idx_s1;
	logic                       vld_s1;
	logic signed [SAMPLE_W-1:0] prod_q15;

	// Floor of the product over 2^15, wrapped to 16 bits.
	assign prod_q15 = prod_s1[PROD_W-2:SAMPLE_W-1];

	always_comb begin
		case (cmd.mul_op)
			OP_FIR: begin
				mul_a = delay_q[cmd.idx];
				mul_b = weight_q[cmd.idx];
			end
			OP_GAIN: begin
				mul_a = $signed(SAMPLE_W'(step_q));
				mul_b = err_q;
			end
			OP_UPD: begin
				mul_a = g_q;
				mul_b = delay_q[cmd.idx];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			step_q <= STEP_RESET;
			for (int i = 0; i < TAPS; i++) begin
				delay_q[i]  <= '0;
				weight_q[i] <= '0;
			end
		end else begin
			vld_s1 <= cmd.mul_en;
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (cmd.shift) begin
				delay_q[0] <= sample_in;
				for (int i = 1; i < TAPS; i++) begin
					delay_q[i] <= delay_q[i-1];
				end
			end
			if (vld_s1 && op_s1 == OP_UPD) begin
				weight_q[idx_s1] <= weight_q[idx_s1] + prod_q15;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
			op_s1   <= cmd.mul_op;
			idx_s1  <= cmd.idx;
		end
		if (cmd.shift) begin
			desired_q <= desired;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (vld_s1 && op_s1 == OP_FIR) begin
			acc_q <= acc_q + prod_q15;
		end
		if (vld_s1 && op_s1 == OP_GAIN) begin
			g_q <= prod_q15;
		end
		if (cmd.err_load) begin
			err_q <= desired_q - acc_q;
		end
		if (cmd.out_load) begin
			filter_q <= acc_q;
			error_q  <= err_q;
		end
	end

	assign filter_out = filter_q;
	assign error_out  = error_q;

endmodule

`default_nettype wire

/* rtl/lms_adaptive_fir_equalizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Ten-tap LMS adaptive equalizer on Q1.15 samples.
// The samples channel carries one word per symbol: a new sample and the desired
// value for it. The results channel returns one word per accepted input: the
// filter output formed before the coefficient update, and the error, desired
// minus that output. Both channels use a valid/ready handshake.
// The step size mu (Q0.15) is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce, and it
// then takes effect on the next accepted word.
// One shared 16x16 multiplier forms all TAPS filter products, the gain product
// and all TAPS update products in turn, so no new word is accepted until the
// update pass is done and the result has gone to the output register.
// The result sits in an output register, so the next input word is accepted
// while an earlier result still waits. If the receiver stalls long enough that
// a second result is ready, the block holds it and takes no new input until the
// first one is taken.
// Reset clears the delay line and the coefficients, loads the step size with
// its default of 328 (about 0.01) and leaves the results channel empty.

module lms_adaptive_fir_equalizer import lms_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lms_in_if.sink                 samples,
	lms_out_if.source              results,
	input  wire logic              cfg_we,
	input  wire logic [STEP_W-1:0] cfg_wdata
);

	lms_cmd_t cmd;

	// Sequencer: walks the filter pass, the error and gain steps and the update pass.
	lms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// Delay line, coefficients, shared multiplier and the output register.
	lms_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample_in  (samples.sample_in),
		.desired    (samples.desired),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.filter_out (results.filter_out),
		.error_out  (results.error_out)
	);

	// Once a word is taken, the block is busy with it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("input accepted again right after a word was taken");

	// A new result never overwrites one the receiver has not taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !results.valid || results.ready)
		else $error("pending result overwritten");

	// Loading the output register presents a result on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> results.valid)
		else $error("loaded result not presented");

	// The multiplier only runs while a word is in flight.
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> !samples.ready)
		else $error("multiplier active while idle");

endmodule

`default_nettype wire
